// ===== rtl/gated_target_track_table_assert.svh =====
// Assertion macros for the gated target track table.
`ifndef GATED_TARGET_TRACK_TABLE_ASSERT_SVH
`define GATED_TARGET_TRACK_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define GTT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GTT_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define GTT_ASSERT(label, clk, rst_n, prop, msg)
`define GTT_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

// ===== rtl/gttt_pkg.sv =====
// Shared types and constants for the gated target track table.
`timescale 1ns / 1ps
package gttt_pkg;
  localparam int MaxTracks = 8;
  localparam int SlotW = 4;
  localparam int CntW = $clog2(MaxTracks + 1);
  localparam int IdxW = $clog2(MaxTracks);

  localparam logic [0:0] CfgMatchDist = 1'b0;
  localparam logic [0:0] CfgPersist = 1'b1;

  typedef enum logic [2:0] {
    StDup = 3'd0,
    StMatch = 3'd1,
    StNew = 3'd2,
    StTrkFull = 3'd3,
    StSeenFull = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    FsmIdle,
    FsmScan,
    FsmDetOut,
    FsmEofAge,
    FsmEofPack,
    FsmEofOut
  } fsm_e;

  // One track entry as held in a cell.
  typedef struct packed {
    logic        live;
    logic        hit;
    logic [11:0] x;
    logic [11:0] y;
    logic [12:0] dx;
    logic [12:0] dy;
    logic [15:0] attr;
    logic [7:0]  age;
    logic [7:0]  missed;
  } track_t;

  // Seen-detection entry.
  typedef struct packed {
    logic        live;
    logic [11:0] x;
    logic [11:0] y;
  } seen_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic        rotate;   // shift ring by one: cell k takes from cell k+1
    logic        upd;      // update head cell (index 0) with detection
    logic        ins;      // write new entry at tail position
    logic        age;      // age / drop head entry on rotate
    logic        clr_hit;
    logic [11:0] x;
    logic [11:0] y;
    logic [15:0] attr;
    logic [7:0]  persist;
  } cell_ctl_t;

  function automatic logic [11:0] cheb(input logic [11:0] ax, input logic [11:0] ay,
                                       input logic [11:0] bx, input logic [11:0] by);
    logic [11:0] ddx;
    logic [11:0] ddy;
    ddx = (ax > bx) ? ax - bx : bx - ax;
    ddy = (ay > by) ? ay - by : by - ay;
    return (ddx > ddy) ? ddx : ddy;
  endfunction
endpackage

// ===== rtl/gttt_cell.sv =====
// One track cell of the rotating track ring.
`timescale 1ns / 1ps
module gttt_cell import gttt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_ctl_t ctl_i,
  input  logic      head_i,     // this cell is ring position 0
  input  logic      tail_i,     // this cell is the insert position
  input  track_t    next_i,     // entry of the neighbor cell
  output track_t    ent_o
);
  track_t ent_q, ent_d, src;
  logic [8:0] miss_w;

  // Age or drop the entry passing through the head on rotation; otherwise update the head or insert at the tail.
  always_comb begin
    src = next_i;
    miss_w = {1'b0, next_i.missed} + 9'd1;
    ent_d = ent_q;
    if (ctl_i.rotate) begin
      if (ctl_i.age && next_i.live && !next_i.hit) begin
        if (miss_w > {1'b0, ctl_i.persist}) begin
          src.live = 1'b0;
        end else begin
          src.missed = miss_w[8] ? 8'hFF : miss_w[7:0];
          if (next_i.age != 8'hFF) src.age = next_i.age + 8'd1;
        end
      end
      if (ctl_i.clr_hit) src.hit = 1'b0;
      ent_d = src;
    end else if (ctl_i.upd && head_i) begin
      ent_d.dx = 13'({1'b0, ctl_i.x}) - 13'({1'b0, ent_q.x});
      ent_d.dy = 13'({1'b0, ctl_i.y}) - 13'({1'b0, ent_q.y});
      ent_d.x = ctl_i.x;
      ent_d.y = ctl_i.y;
      ent_d.attr = ctl_i.attr;
      if (ent_q.age != 8'hFF) ent_d.age = ent_q.age + 8'd1;
      ent_d.missed = '0;
      ent_d.hit = 1'b1;
    end else if (ctl_i.ins && tail_i) begin
      ent_d.live = 1'b1;
      ent_d.hit = 1'b1;
      ent_d.x = ctl_i.x;
      ent_d.y = ctl_i.y;
      ent_d.dx = '0;
      ent_d.dy = '0;
      ent_d.attr = ctl_i.attr;
      ent_d.age = 8'd1;
      ent_d.missed = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
    end else begin
      ent_q <= ent_d;
    end
  end

  assign ent_o = ent_q;
endmodule

// ===== rtl/gated_target_track_table.sv =====
// Top level: sequencer, seen store and ring of track cells.
//
//  channel | handshake                 | payload
//  input   | start / busy              | cmd_i det_x_i det_y_i det_attr_i
//  result  | res_valid_o               | kind_o status_o slot_o track_*_o last_o
//  config  | cfg_valid_i / cfg_ready_o | cfg_index_i cfg_data_i
//
// A detection makes one ring pass past the compare cell, pausing once to update
// a matching entry in place; a new entry goes in as the pass ends, then the
// result is reported. A duplicate or a full seen store is reported with no ring
// pass. End of frame ages each entry in a pass, compacts in another and reports
// the tracks in turn (one report when empty). Start is taken only when idle.
// Reset empties both stores at once; no clearing pass. Results cannot stall.
`timescale 1ns / 1ps
module gated_target_track_table import gttt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cmd_i,
  input  logic [11:0] det_x_i,
  input  logic [11:0] det_y_i,
  input  logic [15:0] det_attr_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i,
  output logic        res_valid_o,
  output logic        kind_o,
  output logic [2:0]  status_o,
  output logic [3:0]  slot_o,
  output logic [11:0] track_x_o,
  output logic [11:0] track_y_o,
  output logic signed [12:0] track_dx_o,
  output logic signed [12:0] track_dy_o,
  output logic [15:0] track_attr_o,
  output logic [7:0]  track_age_o,
  output logic        track_valid_o,
  output logic        last_o
);
  `include "gated_target_track_table_assert.svh"

  fsm_e st_q, st_d;
  logic [11:0] md_q;
  logic [7:0]  pf_q;
  logic [11:0] x_q;
  logic [11:0] y_q;
  logic [15:0] attr_q;
  logic        eas_q, eas_d;
  logic [CntW-1:0] tc_q, tc_d;
  logic [CntW-1:0] sc_q, sc_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic        found_q, found_d;
  logic [SlotW-1:0] fslot_q, fslot_d;
  status_e     dst_q, dst_d;
  logic [CntW-1:0]  wr_q, wr_d;
  logic [IdxW-1:0]  pack_bnd;
  seen_t       seen_q [MaxTracks];
  track_t      ring [MaxTracks];
  cell_ctl_t   ctl;
  logic        dup_w, hit_w, seen_wr;

  // Configuration writes.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      md_q <= 12'd40;
      pf_q <= 8'd5;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgMatchDist: md_q <= cfg_data_i;
        CfgPersist:   pf_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Duplicate check against the seen store, in parallel lanes.
  always_comb begin
    dup_w = 1'b0;
    for (int k = 0; k < MaxTracks; k++) begin
      if (seen_q[k].live && cheb(x_q, y_q, seen_q[k].x, seen_q[k].y) < md_q) dup_w = 1'b1;
    end
  end

  assign hit_w = ring[0].live && !eas_q &&
                 ({1'b0, cheb(x_q, y_q, ring[0].x, ring[0].y)} < {md_q, 1'b0});

  // Last cell of the pack region: skip the dead entries already passed.
  assign pack_bnd = IdxW'(MaxTracks - 1) - IdxW'(cnt_q - wr_q);

  // Sequencer next state.
  always_comb begin
    st_d = st_q;
    eas_d = eas_q;
    tc_d = tc_q;
    sc_d = sc_q;
    cnt_d = cnt_q;
    found_d = found_q;
    fslot_d = fslot_q;
    dst_d = dst_q;
    wr_d = wr_q;
    seen_wr = 1'b0;
    ctl = '0;
    ctl.x = x_q;
    ctl.y = y_q;
    ctl.attr = attr_q;
    ctl.persist = pf_q;
    busy = (st_q != FsmIdle);
    case (st_q)
      FsmIdle: begin
        cnt_d = '0;
        found_d = 1'b0;
        wr_d = '0;
        if (start) st_d = cmd_i ? FsmEofAge : FsmScan;
      end
      FsmScan: begin
        // Rotate the ring fully; match the first live entry in order.
        if (cnt_q == '0 && !found_q && sc_q >= CntW'(MaxTracks)) begin
          fslot_d = '0;
          dst_d = StSeenFull;
          st_d = FsmDetOut;
        end else if (cnt_q == '0 && !found_q && dup_w) begin
          seen_wr = 1'b1;
          sc_d = sc_q + 1'b1;
          fslot_d = '0;
          dst_d = StDup;
          st_d = FsmDetOut;
        end else if (cnt_q == CntW'(MaxTracks)) begin
          st_d = FsmDetOut;
          if (!found_q) begin
            if (tc_q < CntW'(MaxTracks)) begin
              ctl.ins = 1'b1;
              tc_d = tc_q + 1'b1;
              fslot_d = SlotW'(tc_q);
              dst_d = StNew;
            end else begin
              fslot_d = '0;
              dst_d = StTrkFull;
            end
          end
        end else begin
          if (cnt_q == '0 && !found_q) begin
            seen_wr = 1'b1;
            sc_d = sc_q + 1'b1;
          end
          if (!found_q && hit_w && cnt_q < tc_q) begin
            ctl.upd = 1'b1;
            found_d = 1'b1;
            fslot_d = SlotW'(cnt_q);
            dst_d = StMatch;
          end else begin
            ctl.rotate = 1'b1;
          end
          cnt_d = ctl.rotate ? cnt_q + 1'b1 : cnt_q;
        end
      end
      FsmDetOut: st_d = FsmIdle;
      FsmEofAge: begin
        // One pass ages every entry as it crosses the head.
        ctl.rotate = 1'b1;
        ctl.age = 1'b1;
        ctl.clr_hit = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(MaxTracks - 1)) begin
          cnt_d = '0;
          st_d = FsmEofPack;
        end
      end
      FsmEofPack: begin
        // Compact: move live entries from the head to the tail in order.
        ctl.rotate = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (ring[0].live) wr_d = wr_q + 1'b1;
        if (cnt_q == CntW'(MaxTracks - 1)) begin
          cnt_d = '0;
          st_d = FsmEofOut;
          tc_d = ring[0].live ? wr_q + 1'b1 : wr_q;
          eas_d = (tc_d == '0);
          sc_d = '0;
        end
      end
      FsmEofOut: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q + 1'b1 >= tc_q) st_d = FsmIdle;
      end
      default: st_d = FsmIdle;
    endcase
  end

  // Ring of cells; cell k takes from cell k+1, the last takes the head.
  // Age only the entry that leaves the head. In the pack pass a live head drops
  // in behind the packed entries and the cells holding dead ones above it hold.
  for (genvar k = 0; k < MaxTracks; k++) begin : g_cell
    track_t    nxt;
    cell_ctl_t cctl;
    always_comb begin
      nxt = ring[(k + 1) % MaxTracks];
      cctl = ctl;
      if (k != MaxTracks - 1) begin
        cctl.age = 1'b0;
        cctl.clr_hit = 1'b0;
      end
      if (st_q == FsmEofPack && ring[0].live) begin
        if (IdxW'(k) == pack_bnd) nxt = ring[0];
        else if (IdxW'(k) > pack_bnd) cctl.rotate = 1'b0;
      end
    end
    gttt_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctl_i (cctl),
      .head_i(k == 0),
      .tail_i(IdxW'(k) == IdxW'(tc_q)),
      .next_i(nxt),
      .ent_o (ring[k])
    );
  end

  // Registers of the sequencer and the seen store.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= FsmIdle;
      eas_q <= 1'b1;
      tc_q <= '0;
      sc_q <= '0;
      cnt_q <= '0;
      found_q <= 1'b0;
      wr_q <= '0;
      for (int k = 0; k < MaxTracks; k++) seen_q[k] <= '0;
    end else begin
      st_q <= st_d;
      eas_q <= eas_d;
      tc_q <= tc_d;
      sc_q <= sc_d;
      cnt_q <= cnt_d;
      found_q <= found_d;
      wr_q <= wr_d;
      if (st_q == FsmEofPack && st_d == FsmEofOut) begin
        for (int k = 0; k < MaxTracks; k++) seen_q[k].live <= 1'b0;
      end else if (seen_wr) begin
        seen_q[IdxW'(sc_q)] <= '{live: 1'b1, x: x_q, y: y_q};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fslot_q <= fslot_d;
    dst_q <= dst_d;
    if (st_q == FsmIdle && start) begin
      x_q <= det_x_i;
      y_q <= det_y_i;
      attr_q <= det_attr_i;
    end
  end

  // Result port: detection report or one track per cycle.
  always_comb begin
    track_t e;
    logic show;
    status_e s;
    e = ring[0];
    res_valid_o = (st_q == FsmDetOut) || (st_q == FsmEofOut);
    kind_o = (st_q == FsmEofOut);
    last_o = 1'b1;
    show = 1'b0;
    s = StDup;
    slot_o = '0;
    if (st_q == FsmDetOut) begin
      s = dst_q;
      show = (dst_q == StMatch) || (dst_q == StNew);
      e = ring[IdxW'(fslot_q)];
      slot_o = fslot_q;
    end else if (st_q == FsmEofOut) begin
      show = (tc_q != '0);
      e = ring[IdxW'(cnt_q)];
      slot_o = SlotW'(cnt_q);
      last_o = (cnt_q + 1'b1 >= tc_q);
    end
    status_o = s;
    if (!show) slot_o = '0;
    track_valid_o = show;
    track_x_o = show ? e.x : '0;
    track_y_o = show ? e.y : '0;
    track_dx_o = show ? e.dx : '0;
    track_dy_o = show ? e.dy : '0;
    track_attr_o = show ? e.attr : '0;
    track_age_o = show ? e.age : '0;
  end

  `GTT_ASSERT(a_count_bound, clk_i, rst_ni, tc_q <= CntW'(MaxTracks), "track count overflow")
  `GTT_ASSERT(a_seen_bound, clk_i, rst_ni, sc_q <= CntW'(MaxTracks), "seen count overflow")
  `GTT_ASSERT(a_result_busy, clk_i, rst_ni, res_valid_o |-> busy, "result while idle")
endmodule

// ===== sim/gated_target_track_table_tb.sv =====
// Self-checking testbench for the gated target track table.
`timescale 1ns / 1ps
module gated_target_track_table_tb import gttt_pkg::*; ();

  localparam int unsigned WatchLimit = 20000;

  typedef struct packed {
    logic        cmd;
    logic [11:0] x;
    logic [11:0] y;
    logic [15:0] attr;
  } det_item_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  status;
    logic [3:0]  slot;
    logic [11:0] tx;
    logic [11:0] ty;
    logic [12:0] tdx;
    logic [12:0] tdy;
    logic [15:0] tattr;
    logic [7:0]  tage;
    logic        tvalid;
    logic        last;
  } report_t;

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [12:0] dx;
    logic [12:0] dy;
    logic [15:0] attr;
    logic [7:0]  age;
    logic [7:0]  missed;
    logic        hit;
  } trk_entry_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        cmd_i = 1'b0;
  logic [11:0] det_x_i = '0;
  logic [11:0] det_y_i = '0;
  logic [15:0] det_attr_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [0:0]  cfg_index_i = '0;
  logic [11:0] cfg_data_i = '0;
  logic        res_valid_o;
  logic        kind_o;
  logic [2:0]  status_o;
  logic [3:0]  slot_o;
  logic [11:0] track_x_o;
  logic [11:0] track_y_o;
  logic signed [12:0] track_dx_o;
  logic signed [12:0] track_dy_o;
  logic [15:0] track_attr_o;
  logic [7:0]  track_age_o;
  logic        track_valid_o;
  logic        last_o;

  gated_target_track_table dut (.*);

  always #10 clk_i = ~clk_i;

  // Predictor state
  logic [11:0] gate_dist;
  logic [7:0]  persist_lim;
  trk_entry_t  tracks [MaxTracks];
  int unsigned n_tracks;
  logic [11:0] frame_x [MaxTracks];
  logic [11:0] frame_y [MaxTracks];
  int unsigned n_seen;
  bit          table_empty_sof;

  det_item_t   pending_q[$];
  report_t     expected_q[$];
  int unsigned n_errors = 0;
  int unsigned n_accepted = 0;
  int unsigned n_reports = 0;
  int unsigned n_matched = 0;
  int unsigned n_full = 0;
  int unsigned idle_cycles = 0;
  bit          drive_en = 1'b0;
  bit          sender_hold = 1'b0;
  int unsigned gap_left = 0;
  logic        busy_q = 1'b1;

  function automatic logic [11:0] span(logic [11:0] a, logic [11:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [11:0] chebyshev(logic [11:0] ax, logic [11:0] ay,
                                            logic [11:0] bx, logic [11:0] by);
    logic [11:0] ddx;
    logic [11:0] ddy;
    ddx = span(ax, bx);
    ddy = span(ay, by);
    return (ddx > ddy) ? ddx : ddy;
  endfunction

  function automatic report_t track_report(bit kind, status_e st, int unsigned idx,
                                           bit valid, bit last);
    report_t r;
    r = '0;
    r.kind = kind;
    r.status = st;
    r.last = last;
    if (valid) begin
      r.slot = 4'(idx);
      r.tx = tracks[idx].x;
      r.ty = tracks[idx].y;
      r.tdx = tracks[idx].dx;
      r.tdy = tracks[idx].dy;
      r.tattr = tracks[idx].attr;
      r.tage = tracks[idx].age;
      r.tvalid = 1'b1;
    end
    return r;
  endfunction

  // Associate a detection with the table and queue its report
  task automatic associate(det_item_t it);
    bit dup;
    logic [12:0] tgate;
    dup = 1'b0;
    if (n_seen >= MaxTracks) begin
      expected_q.push_back(track_report(1'b0, StSeenFull, 0, 1'b0, 1'b1));
      return;
    end
    for (int i = 0; i < n_seen; i++)
      if (chebyshev(it.x, it.y, frame_x[i], frame_y[i]) < gate_dist) dup = 1'b1;
    frame_x[n_seen] = it.x;
    frame_y[n_seen] = it.y;
    n_seen++;
    if (dup) begin
      expected_q.push_back(track_report(1'b0, StDup, 0, 1'b0, 1'b1));
      return;
    end
    tgate = {1'b0, gate_dist} << 1;
    if (!table_empty_sof) begin
      for (int i = 0; i < n_tracks; i++) begin
        if ({1'b0, chebyshev(it.x, it.y, tracks[i].x, tracks[i].y)} < tgate) begin
          tracks[i].dx = {1'b0, it.x} - {1'b0, tracks[i].x};
          tracks[i].dy = {1'b0, it.y} - {1'b0, tracks[i].y};
          tracks[i].x = it.x;
          tracks[i].y = it.y;
          tracks[i].attr = it.attr;
          if (tracks[i].age != 8'hFF) tracks[i].age++;
          tracks[i].missed = '0;
          tracks[i].hit = 1'b1;
          expected_q.push_back(track_report(1'b0, StMatch, i, 1'b1, 1'b1));
          return;
        end
      end
    end
    if (n_tracks >= MaxTracks) begin
      expected_q.push_back(track_report(1'b0, StTrkFull, 0, 1'b0, 1'b1));
      return;
    end
    tracks[n_tracks] = '{x: it.x, y: it.y, dx: '0, dy: '0, attr: it.attr,
                         age: 8'd1, missed: '0, hit: 1'b1};
    expected_q.push_back(track_report(1'b0, StNew, n_tracks, 1'b1, 1'b1));
    n_tracks++;
  endtask

  // Age, drop and compact the table, then queue one report per track
  task automatic close_frame();
    int unsigned w;
    bit keep;
    logic [8:0] m;
    w = 0;
    for (int i = 0; i < n_tracks; i++) begin
      keep = 1'b1;
      if (!tracks[i].hit) begin
        m = {1'b0, tracks[i].missed} + 9'd1;
        if (m > {1'b0, persist_lim}) keep = 1'b0;
        else begin
          tracks[i].missed = (m > 9'd255) ? 8'hFF : m[7:0];
          if (tracks[i].age != 8'hFF) tracks[i].age++;
        end
      end
      tracks[i].hit = 1'b0;
      if (keep) begin
        tracks[w] = tracks[i];
        w++;
      end
    end
    n_tracks = w;
    n_seen = 0;
    table_empty_sof = (n_tracks == 0);
    if (n_tracks == 0) expected_q.push_back(track_report(1'b1, StDup, 0, 1'b0, 1'b1));
    for (int i = 0; i < n_tracks; i++)
      expected_q.push_back(track_report(1'b1, StDup, i, 1'b1, i + 1 == n_tracks));
  endtask

  // Driver: present queued items at the falling edge, with random gaps
  always @(negedge clk_i) begin
    if (start && !busy_q) begin
      // Transaction taken at the last rising edge: drop start and pick a gap
      start <= 1'b0;
      gap_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) :
                  ($urandom_range(0, 1) ? 0 : $urandom_range(1, 3));
    end else if (!start && drive_en && !sender_hold && pending_q.size() != 0) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
      end else begin
        start <= 1'b1;
        cmd_i <= pending_q[0].cmd;
        det_x_i <= pending_q[0].x;
        det_y_i <= pending_q[0].y;
        det_attr_i <= pending_q[0].attr;
      end
    end
  end

  // Busy as seen at the last rising edge
  always @(posedge clk_i) busy_q <= busy;

  // Accept items and check results at the rising edge
  always @(posedge clk_i) begin
    report_t got;
    report_t want;
    if (rst_ni && start && !busy) begin
      det_item_t it;
      it = pending_q.pop_front();
      if (it.cmd) close_frame();
      else associate(it);
      n_accepted++;
    end
    if (rst_ni) begin
      if ((start && !busy) || res_valid_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
    if (rst_ni && res_valid_o) begin
      got = '{kind_o, status_o, slot_o, track_x_o, track_y_o, track_dx_o, track_dy_o,
              track_attr_o, track_age_o, track_valid_o, last_o};
      n_reports++;
      if (expected_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_q.pop_front();
        if (want.status == StMatch && !want.kind) n_matched++;
        if (want.status == StTrkFull && !want.kind) n_full++;
        if (got !== want) begin
          n_errors++;
          if (n_errors <= 10) $display("mismatch: expected %h got %h", want, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= WatchLimit) begin
      $display("watchdog expired");
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Write one register through the config channel
  task automatic write_reg(logic [0:0] idx, logic [11:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CfgMatchDist) gate_dist = val;
    else persist_lim = val[7:0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || start || expected_q.size() != 0) @(posedge clk_i);
    repeat (3 * MaxTracks + 8) @(posedge clk_i);
  endtask

  function automatic det_item_t det(logic [11:0] x, logic [11:0] y, logic [15:0] a);
    return '{cmd: 1'b0, x: x, y: y, attr: a};
  endfunction

  function automatic det_item_t eof();
    return '{cmd: 1'b1, x: 12'($urandom), y: 12'($urandom), attr: 16'($urandom)};
  endfunction

  // Queue a frame of targets drifting near a small set of centres
  task automatic queue_frame(int unsigned n, logic [11:0] cx [4], int unsigned jit);
    for (int i = 0; i < n; i++) begin
      int unsigned k;
      k = $urandom_range(0, 3);
      if ($urandom_range(0, 7) == 0)
        pending_q.push_back(det(12'($urandom), 12'($urandom), 16'($urandom)));
      else
        pending_q.push_back(det(cx[k] + 12'($urandom_range(0, jit)), cx[3 - k] +
                                12'($urandom_range(0, jit)), 16'($urandom)));
    end
    pending_q.push_back(eof());
  endtask

  initial begin
    logic [11:0] centers [4];
    gate_dist = 12'd40;
    persist_lim = 8'd5;
    n_tracks = 0;
    n_seen = 0;
    table_empty_sof = 1'b1;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    drive_en = 1'b1;

    // Directed: empty frame, extremes, duplicates, matches, store overflow
    pending_q.push_back(eof());
    pending_q.push_back(det(12'd0, 12'd0, 16'h0000));
    pending_q.push_back(det(12'hFFF, 12'hFFF, 16'hFFFF));
    pending_q.push_back(det(12'd39, 12'd0, 16'h1234));
    pending_q.push_back(det(12'd40, 12'd40, 16'h5555));
    pending_q.push_back(eof());
    pending_q.push_back(det(12'd79, 12'd5, 16'hAAAA));
    pending_q.push_back(det(12'hFFF - 12'd80, 12'hFFF, 16'h0F0F));
    pending_q.push_back(det(12'd200, 12'd200, 16'h00FF));
    pending_q.push_back(det(12'd300, 12'd300, 16'h0001));
    pending_q.push_back(det(12'd400, 12'd400, 16'h0002));
    pending_q.push_back(det(12'd500, 12'd500, 16'h0003));
    pending_q.push_back(det(12'd600, 12'd600, 16'h0004));
    pending_q.push_back(det(12'd700, 12'd700, 16'h0005));
    pending_q.push_back(det(12'd800, 12'd800, 16'h0006));
    pending_q.push_back(eof());
    pending_q.push_back(det(12'd900, 12'd900, 16'h0007));
    pending_q.push_back(det(12'd1000, 12'd1000, 16'h0008));
    pending_q.push_back(eof());
    drain();

    // Let tracks time out with a short persistence
    write_reg(CfgPersist, 12'd0);
    write_reg(CfgMatchDist, 12'd0);
    pending_q.push_back(det(12'd7, 12'd7, 16'h7777));
    pending_q.push_back(det(12'd7, 12'd7, 16'h7778));
    pending_q.push_back(eof());
    pending_q.push_back(eof());
    drain();

    // Random phases across register settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(CfgMatchDist, 12'hFFF); write_reg(CfgPersist, 12'hFF); end
        1: begin write_reg(CfgMatchDist, 12'd1); write_reg(CfgPersist, 12'd1); end
        default: begin
          write_reg(CfgMatchDist, 12'($urandom_range(8, 200)));
          write_reg(CfgPersist, 12'($urandom_range(0, 6)));
        end
      endcase
      for (int c = 0; c < 4; c++) centers[c] = 12'($urandom);
      for (int f = 0; f < 7; f++) begin
        queue_frame($urandom_range(0, 10), centers, 2 * gate_dist + 4);
        for (int c = 0; c < 4; c++) centers[c] = centers[c] + 12'($urandom_range(0, 20));
      end
      // Hold the sender until all outstanding results are in
      if (ph == 3) begin
        while (pending_q.size() != 0) @(posedge clk_i);
        sender_hold = 1'b1;
        while (expected_q.size() != 0 || start) @(posedge clk_i);
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
        sender_hold = 1'b0;
      end
      drain();
    end

    $display("covered %0d items, %0d results, %0d matches, %0d table-full drops",
             n_accepted, n_reports, n_matched, n_full);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("mismatches: %0d", n_errors);
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
